// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned CapW   = 5;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  localparam word_t WordNone = '1;  // -1

  typedef struct packed {
    func_e func;
    word_t push_value;
  } deq_in_t;

  typedef struct packed {
    word_t              popped_value;
    status_e            status;
    word_t              front_value;
    word_t              rear_value;
    logic [CountW-1:0]  entry_count;
  } deq_out_t;

  // Per-beat control broadcast along one chain of cells.
  typedef struct packed {
    logic shr;     // shift toward higher index, cell 0 takes the push word
    logic shl;     // shift toward lower index
    logic ld_cnt;  // cell whose index equals the count takes the push word
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of a shifting chain; moves its word to a neighbor or loads anew.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire                  clk_i,
  input  bdq_pkg::cell_ctrl_t  ctrl_i,
  input  wire [CW-1:0]         count_i,
  input  bdq_pkg::word_t       push_i,
  input  bdq_pkg::word_t       left_i,
  input  bdq_pkg::word_t       right_i,
  output bdq_pkg::word_t       data_o,
  output bdq_pkg::word_t       next_o
);
  import bdq_pkg::*;

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ld_cnt && (count_i == CW'(IDX))) begin
      data_d = push_i;
    end else if (ctrl_i.shr) begin
      data_d = (IDX == 0) ? push_i : left_i;
    end else if (ctrl_i.shl) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

`default_nettype wire

// ===== rtl/bdq_chain.sv =====
// ----------------------------------------------------------------------------
// bdq_chain
// Row of DEPTH cells; cell 0 holds the end of the queue this chain faces.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_chain #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  wire                  clk_i,
  input  bdq_pkg::cell_ctrl_t  ctrl_i,
  input  wire [CW-1:0]         count_i,
  input  bdq_pkg::word_t       push_i,
  output bdq_pkg::word_t       head_o,
  output bdq_pkg::word_t       head_next_o
);
  import bdq_pkg::*;

  word_t data  [DEPTH];
  word_t nexts [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = push_i;
    end else begin : g_mid_l
      assign left_w = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = WordNone;
    end else begin : g_mid_r
      assign right_w = data[i+1];
    end

    bdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .push_i  (push_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data[i]),
      .next_o  (nexts[i])
    );
  end

  assign head_o      = data[0];
  assign head_next_o = nexts[0];

endmodule

`default_nettype wire

// ===== rtl/bounded_double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// Output: the result is registered on the edge that accepts the input beat.
// Throughput: one operation per cycle unless out_stall_i holds a result;
//   cells update in parallel, so the chains set the pace, not any memory port.
// Reset: count cleared, capacity 16; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // operation beats
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  bdq_pkg::deq_in_t       in_data_i,
  // result beats
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output bdq_pkg::deq_out_t      out_data_o,
  // capacity register write
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [bdq_pkg::CapW-1:0] cfg_data_i
);
  import bdq_pkg::*;

  // Count must hold DEPTH itself; compare width covers count and capacity.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  // Two chains hold the same entries. The front chain keeps the front entry
  // in cell 0 and entry k in cell k; the rear chain keeps the rear entry in
  // cell 0 and the entries in reverse order. A push at one end shifts that
  // end's chain and drops the word into cell <count> of the other chain; a
  // pop shifts only its own chain, the other one just loses its last entry
  // through the count. Front and rear are then always at cell 0.

  logic [CW-1:0]   count_q, count_d;
  logic [CapW-1:0] cap_q;
  logic            out_valid_q;
  deq_out_t        out_q, out_d;

  logic            in_acc;
  logic            is_push;
  logic            full, empty;
  logic            op_ok;
  logic [MW-1:0]   cap_eff;
  cell_ctrl_t      f_ctrl, r_ctrl;
  word_t           f_head, f_head_d, r_head, r_head_d;

  // Config is taken at any time; the user writes it only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  // Output register parts the two sides: a new beat enters whenever the
  // result slot is empty or being drained this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign is_push = (in_data_i.func == FUNC_PUSH_FRONT) ||
                   (in_data_i.func == FUNC_PUSH_BACK);

  // Capacity above DEPTH saturates; zero capacity means always full.
  assign cap_eff = (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);
  assign full    = (MW'(count_q) >= cap_eff);
  assign empty   = (count_q == '0);
  assign op_ok   = is_push ? ~full : ~empty;

  // Chain controls
  always_comb begin
    f_ctrl = '0;
    r_ctrl = '0;
    if (in_acc && op_ok) begin
      case (in_data_i.func)
        FUNC_PUSH_FRONT: begin
          f_ctrl.shr    = 1'b1;
          r_ctrl.ld_cnt = 1'b1;
        end
        FUNC_PUSH_BACK: begin
          f_ctrl.ld_cnt = 1'b1;
          r_ctrl.shr    = 1'b1;
        end
        FUNC_POP_FRONT: begin
          f_ctrl.shl = 1'b1;
        end
        FUNC_POP_BACK: begin
          r_ctrl.shl = 1'b1;
        end
        default: begin
          f_ctrl = '0;
          r_ctrl = '0;
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (in_acc && op_ok) begin
      count_d = is_push ? count_q + CW'(1) : count_q - CW'(1);
    end
  end

  bdq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_front (
    .clk_i       (clk_i),
    .ctrl_i      (f_ctrl),
    .count_i     (count_q),
    .push_i      (in_data_i.push_value),
    .head_o      (f_head),
    .head_next_o (f_head_d)
  );

  bdq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_rear (
    .clk_i       (clk_i),
    .ctrl_i      (r_ctrl),
    .count_i     (count_q),
    .push_i      (in_data_i.push_value),
    .head_o      (r_head),
    .head_next_o (r_head_d)
  );

  // Result beat: popped word is the pre-op head of the popped end, front and
  // rear are the post-op heads.
  always_comb begin
    out_d              = out_q;
    out_d.popped_value = WordNone;
    out_d.status       = STATUS_OK;
    if (!op_ok) begin
      out_d.status = is_push ? STATUS_FULL : STATUS_EMPTY;
    end else if (in_data_i.func == FUNC_POP_FRONT) begin
      out_d.popped_value = f_head;
    end else if (in_data_i.func == FUNC_POP_BACK) begin
      out_d.popped_value = r_head;
    end
    out_d.front_value = (count_d == '0) ? WordNone : f_head_d;
    out_d.rear_value  = (count_d == '0) ? WordNone : r_head_d;
    out_d.entry_count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CapW'(16);
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(count_q) <= MW'(DEPTH))
    else $error("entry count above DEPTH");

  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_push && full) |=> $stable(count_q))
    else $error("refused push changed the count");

  a_empty_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_push && empty) |=> (out_q.status == STATUS_EMPTY))
    else $error("pop on empty queue not flagged");

  a_count_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_q.entry_count == CountW'(count_q)))
    else $error("reported count differs from held count");
`endif

endmodule

`default_nettype wire

// ===== tb/bounded_double_ended_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core_test
// Drives push/pop beats into the deque core under random valid gaps and
// result stalls, mirrors the ring of entries in a scoreboard and checks each
// result beat field by field. Capacity is rewritten between phases while the
// core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_core_test;
  import bdq_pkg::*;

  localparam int unsigned SlotsN = 16;

  // Mirror of the deque: ring of slots, head, count and capacity.
  class deque_mirror;
    word_t             slots [SlotsN];
    logic [3:0]        head;
    logic [CountW-1:0] held;
    logic [CapW-1:0]   cap;
    deq_out_t          outcomes_due [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       full_refusals;
    int unsigned       empty_refusals;

    function new();
      head = '0;
      held = '0;
      cap  = 5'd16;
    endfunction

    function void set_capacity(logic [CapW-1:0] c);
      cap = c;
    endfunction

    function int unsigned pending();
      return outcomes_due.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce.
    function void note_operation(deq_in_t op);
      deq_out_t    r;
      int unsigned limit;
      logic [3:0]  idx;
      r.popped_value = WordNone;
      r.status       = STATUS_OK;
      r.front_value  = WordNone;
      r.rear_value   = WordNone;
      limit = (cap > SlotsN) ? SlotsN : cap;
      if (op.func == FUNC_PUSH_FRONT || op.func == FUNC_PUSH_BACK) begin
        if (held >= limit) begin
          r.status = STATUS_FULL;
          full_refusals++;
        end else if (op.func == FUNC_PUSH_FRONT) begin
          head = head - 4'd1;
          slots[head] = op.push_value;
          held++;
        end else begin
          idx = head + held[3:0];
          slots[idx] = op.push_value;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
          empty_refusals++;
        end else if (op.func == FUNC_POP_FRONT) begin
          r.popped_value = slots[head];
          head = head + 4'd1;
          held--;
        end else begin
          idx = head + 4'(held - 1);
          r.popped_value = slots[idx];
          held--;
        end
      end
      if (held != 0) begin
        idx = head + 4'(held - 1);
        r.front_value = slots[head];
        r.rear_value  = slots[idx];
      end
      r.entry_count = held;
      outcomes_due = {outcomes_due, r};
    endfunction

    function void check_result(deq_out_t got);
      deq_out_t exp;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat with nothing pending: %p", got);
        return;
      end
      exp = outcomes_due[0];
      outcomes_due.delete(0);
      checked++;
      if (got.popped_value !== exp.popped_value || got.status !== exp.status ||
          got.front_value !== exp.front_value || got.rear_value !== exp.rear_value ||
          got.entry_count !== exp.entry_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  exp popped=%0d status=%0d front=%0d rear=%0d count=%0d",
                   exp.popped_value, exp.status, exp.front_value, exp.rear_value,
                   exp.entry_count);
          $display("  got popped=%0d status=%0d front=%0d rear=%0d count=%0d",
                   got.popped_value, got.status, got.front_value, got.rear_value,
                   got.entry_count);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  deq_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  deq_out_t          out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CapW-1:0]   cfg_data_i;

  deque_mirror       mirror;
  int unsigned       idle_pct;
  int unsigned       ops_sent;
  int unsigned       caps_written;

  bounded_double_ended_queue_core #(.DEPTH(SlotsN)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: random stall, check every accepted beat.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        mirror.check_result(out_data_o);
      out_stall_i <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  function automatic deq_in_t make_op(func_e f, word_t v);
    deq_in_t op;
    op.func       = f;
    op.push_value = v;
    return op;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return WordNone;
      3:       return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_op(deq_in_t op);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= make_op(func_e'($urandom_range(3)), word_t'($urandom));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_operation(op);
    ops_sent++;
  endtask

  // Wait, bounded, for all pending results, then add slack before returning.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (mirror.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] c);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mirror.set_capacity(c);
    caps_written++;
  endtask

  task automatic send_batch(deq_in_t ops [$]);
    foreach (ops[i]) send_op(ops[i]);
    in_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, int unsigned push_pct);
    deq_in_t op;
    repeat (count) begin
      if ($urandom_range(99) < push_pct)
        op = make_op($urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_word());
      else
        op = make_op($urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT,
                     word_t'($urandom));
      send_op(op);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    deq_in_t     ops [$];
    int unsigned failures;
    mirror       = new();
    idle_pct     = 23;
    ops_sent     = 0;
    caps_written = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty refusals, field extremes, both ends.
    write_capacity(5'd16);
    ops = '{make_op(FUNC_POP_FRONT, '0), make_op(FUNC_POP_BACK, '0),
            make_op(FUNC_PUSH_FRONT, 32'sh8000_0000),
            make_op(FUNC_PUSH_BACK, 32'sh7fff_ffff),
            make_op(FUNC_PUSH_FRONT, WordNone), make_op(FUNC_PUSH_BACK, '0),
            make_op(FUNC_POP_FRONT, '0), make_op(FUNC_POP_BACK, '0),
            make_op(FUNC_POP_BACK, '0), make_op(FUNC_POP_FRONT, '0),
            make_op(FUNC_POP_FRONT, '0)};
    send_batch(ops);

    // Small capacity reached from both ends.
    write_capacity(5'd2);
    ops = '{make_op(FUNC_PUSH_BACK, 32'sd5), make_op(FUNC_PUSH_FRONT, 32'sd6),
            make_op(FUNC_PUSH_BACK, 32'sd7)};
    send_batch(ops);

    // Zero capacity: always full, pops still drain.
    write_capacity(5'd0);
    ops = '{make_op(FUNC_PUSH_FRONT, 32'sd8), make_op(FUNC_POP_BACK, '0),
            make_op(FUNC_POP_FRONT, '0), make_op(FUNC_POP_FRONT, '0)};
    send_batch(ops);

    // Capacity dropped below the held count.
    write_capacity(5'd3);
    ops = '{make_op(FUNC_PUSH_BACK, 32'shaaaa_5555), make_op(FUNC_PUSH_BACK, 32'sh5555_aaaa),
            make_op(FUNC_PUSH_FRONT, 32'sd1)};
    send_batch(ops);
    write_capacity(5'd1);
    ops = '{make_op(FUNC_PUSH_FRONT, 32'sd2), make_op(FUNC_POP_BACK, '0),
            make_op(FUNC_POP_FRONT, '0), make_op(FUNC_PUSH_BACK, 32'sd3),
            make_op(FUNC_POP_FRONT, '0), make_op(FUNC_PUSH_BACK, 32'sd4),
            make_op(FUNC_POP_BACK, '0)};
    send_batch(ops);

    // Random phases, push bias varied to sweep the fill level.
    for (int p = 0; p < 10; p++) begin
      idle_pct = 23;
      case (p)
        0: begin write_capacity(5'd16); random_phase(100, 65); end
        1: begin write_capacity(5'd16); random_phase(100, 35); end
        2: begin write_capacity(5'd31); random_phase(110, 62); end
        3: begin write_capacity(5'd1);  random_phase(80, 50);  end
        4: begin write_capacity(5'd0);  random_phase(30, 50);  end
        5: begin write_capacity(5'd4);  random_phase(90, 55);  end
        6: begin
          write_capacity(5'($urandom_range(16, 6)));
          idle_pct = 0;  // back-to-back stretch
          random_phase(150, 70);
        end
        7: begin write_capacity(5'd3);  random_phase(100, 50); end
        8: begin write_capacity(5'($urandom_range(31))); random_phase(120, 50); end
        default: begin write_capacity(5'd16); random_phase(100, 40); end
      endcase
    end

    settle();
    failures = mirror.mismatches + mirror.pending();
    $display("Ran %0d operations over %0d capacity writes, %0d results checked.",
             ops_sent, caps_written, mirror.checked);
    $display("Refusals seen: %0d full, %0d empty; %0d errors.",
             mirror.full_refusals, mirror.empty_refusals, failures);
    if (failures == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bdq_chain.sv
rtl/bounded_double_ended_queue_core.sv
tb/bounded_double_ended_queue_core_test.sv
